/* rtl/assert_macros.svh */
// Assertion macros shared by the chunked decoder modules.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// When ante holds at a clock edge, cons holds at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// When ante holds at a clock edge, cons holds at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// cond never holds at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* rtl/cdec_pkg.sv */
`timescale 1ns / 1ps

package cdec_pkg;

    localparam int SIZE_BITS_DEFAULT = 31;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    // One decoded result per accepted byte.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       payload_valid;
        logic       chunk_last;
        logic       body_done;
        logic       format_error;
    } result_t;

    function automatic logic is_blank(input logic [7:0] c);
        logic r;
        r = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
            (c == CH_VT) || (c == CH_FF);
        return r;
    endfunction

    // Bit 4 flags a hex digit; bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

/* rtl/cdec_core.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cdec_core #(
    parameter int SIZE_BITS = cdec_pkg::SIZE_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              start_body,
    output cdec_pkg::result_t result
);

    typedef enum logic [2:0] {
        PH_LEAD, PH_SIGN, PH_DIGITS, PH_TRAIL, PH_PAYLOAD, PH_SKIP, PH_DONE, PH_ERROR
    } phase_t;

    phase_t               phase_reg, phase_next, phase_cur;
    logic [SIZE_BITS-1:0] size_reg, size_next, size_cur;
    logic                 digit_reg, digit_next, digit_cur;
    logic                 lone_reg, lone_next, lone_cur;
    logic [SIZE_BITS-1:0] rem_reg, rem_next, rem_cur;

    logic [4:0]           hex;
    logic                 blank;
    logic                 overflow;
    logic [SIZE_BITS-1:0] size_shifted;

    always_comb
    begin
        // A start flag makes this byte see the reset state.
        phase_cur = start_body ? PH_LEAD : phase_reg;
        size_cur  = start_body ? '0 : size_reg;
        digit_cur = start_body ? 1'b0 : digit_reg;
        lone_cur  = start_body ? 1'b0 : lone_reg;
        rem_cur   = start_body ? '0 : rem_reg;

        hex          = cdec_pkg::hex_digit(in_byte);
        blank        = cdec_pkg::is_blank(in_byte);
        overflow     = |size_cur[SIZE_BITS-1 -: 4];
        size_shifted = {size_cur[SIZE_BITS-5:0], hex[3:0]};

        phase_next = phase_cur;
        size_next  = size_cur;
        digit_next = digit_cur;
        lone_next  = lone_cur;
        rem_next   = rem_cur;
        result     = '0;

        case (phase_cur)
            PH_LEAD, PH_SIGN:
            begin
                if (in_byte == cdec_pkg::CH_LF)
                begin
                    phase_next = PH_ERROR;
                end
                else if (phase_cur == PH_LEAD && blank)
                begin
                    phase_next = PH_LEAD;
                end
                else if (phase_cur == PH_LEAD && in_byte == cdec_pkg::CH_PLUS)
                begin
                    phase_next = PH_SIGN;
                end
                else if (hex[4] && !overflow)
                begin
                    size_next  = size_shifted;
                    lone_next  = !digit_cur && (hex[3:0] == 4'd0);
                    digit_next = 1'b1;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
            PH_DIGITS, PH_TRAIL:
            begin
                if (in_byte == cdec_pkg::CH_LF)
                begin
                    if (!digit_cur)
                    begin
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        phase_next = (size_cur == '0) ? PH_DONE : PH_PAYLOAD;
                        if (size_cur != '0)
                        begin
                            rem_next = size_cur;
                        end
                        size_next  = '0;
                        digit_next = 1'b0;
                        lone_next  = 1'b0;
                    end
                end
                else if (phase_cur == PH_TRAIL)
                begin
                    if (!blank)
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                else if (hex[4])
                begin
                    if (overflow)
                    begin
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        size_next  = size_shifted;
                        lone_next  = 1'b0;
                        digit_next = 1'b1;
                    end
                end
                else if ((in_byte == cdec_pkg::CH_LOW_X || in_byte == cdec_pkg::CH_UP_X)
                         && lone_cur)
                begin
                    // The leading zero was a 0x prefix; digits must follow.
                    lone_next  = 1'b0;
                    digit_next = 1'b0;
                    size_next  = '0;
                end
                else if (blank && digit_cur)
                begin
                    phase_next = PH_TRAIL;
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
            PH_PAYLOAD:
            begin
                result.out_byte      = in_byte;
                result.payload_valid = 1'b1;
                rem_next             = rem_cur - SIZE_BITS'(1);
                if (rem_cur == SIZE_BITS'(1))
                begin
                    result.chunk_last = 1'b1;
                    phase_next        = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if (in_byte == cdec_pkg::CH_LF)
                begin
                    phase_next = PH_LEAD;
                end
            end
            default:
            begin
                phase_next = phase_cur;
            end
        endcase

        result.body_done    = (phase_next == PH_DONE);
        result.format_error = (phase_next == PH_ERROR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            size_reg  <= '0;
            digit_reg <= 1'b0;
            lone_reg  <= 1'b0;
            rem_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            size_reg  <= size_next;
            digit_reg <= digit_next;
            lone_reg  <= lone_next;
            rem_reg   <= rem_next;
        end
    end

    `ASSERT_IMPLIES(a_last_is_payload, clk, rst_n, accept && result.chunk_last,
                    result.payload_valid)
    `ASSERT_NEVER(a_done_error_excl, clk, rst_n,
                  accept && result.body_done && result.format_error)
    `ASSERT_IMPLIES(a_done_sticks, clk, rst_n, accept && !start_body && phase_reg == PH_DONE,
                    result.body_done && !result.payload_valid)

endmodule

/* rtl/cdec_outreg.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cdec_outreg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  cdec_pkg::result_t result,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_ready,
    output cdec_pkg::result_t result_out
);

    cdec_pkg::result_t result_reg;
    logic              valid_reg;

    // The register may take a new request in the cycle its content leaves.
    assign ready      = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    `ASSERT_NEXT(a_load_shows, clk, rst_n, load, valid_reg && result_reg == $past(result))
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, load && valid_reg && !out_ready)

endmodule

/* rtl/chunked_transfer_decoder_top.sv */
`timescale 1ns / 1ps
// Chunked transfer decoder: takes one raw body byte per request and returns
// one result per request.
// Input channel: in_valid/in_ready with in_byte and start_body. A high
// start_body restarts decoding at a size line before its byte is handled.
// Output channel: out_valid/out_ready with out_byte, payload_valid,
// chunk_last, body_done and format_error.
// A result is registered and shows the cycle after its byte is accepted.
// One byte per cycle while the receiver keeps taking results; the decode
// logic from the state registers to the output register is combinational.
// When the receiver stalls, the result waits in the output register and
// in_ready drops until it is taken; in the cycle it is taken a new byte is
// accepted. Reset clears the decoder state and empties the output register;
// no byte is lost or repeated across a stall.
// body_done and format_error stay high until the next start_body.

module chunked_transfer_decoder_top #(
    parameter int SIZE_BITS = cdec_pkg::SIZE_BITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       start_body,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       payload_valid,
    output logic       chunk_last,
    output logic       body_done,
    output logic       format_error
);

    logic              accept;
    cdec_pkg::result_t step_result;
    cdec_pkg::result_t held_result;

    assign accept = in_valid && in_ready;

    cdec_core #(
        .SIZE_BITS(SIZE_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .start_body(start_body),
        .result    (step_result)
    );

    cdec_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .result    (step_result),
        .ready     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result_out(held_result)
    );

    assign out_byte      = held_result.out_byte;
    assign payload_valid = held_result.payload_valid;
    assign chunk_last    = held_result.chunk_last;
    assign body_done     = held_result.body_done;
    assign format_error  = held_result.format_error;

endmodule

/* dv/tb_chunked_transfer_decoder_top.sv */
`timescale 1ns / 1ps

module tb_chunked_transfer_decoder_top;

    localparam int SZ = cdec_pkg::SIZE_BITS_DEFAULT;
    localparam logic [SZ-1:0] SIZE_LIMIT = '1;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;

    typedef enum logic [2:0] {
        P_LEAD, P_SIGN, P_DIGITS, P_TRAIL, P_PAYLOAD, P_SKIP, P_DONE, P_ERROR
    } dec_phase_e;

    typedef struct packed {
        logic [7:0] b;
        logic       st;
    } req_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       start_body = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       payload_valid;
    logic       chunk_last;
    logic       body_done;
    logic       format_error;

    req_t                pending[$];
    cdec_pkg::result_t   expected_results[$];
    logic [7:0]          body_q[$];
    int unsigned         items_sent = 0;
    int unsigned         err_cnt = 0;
    int unsigned         cyc = 0;
    logic                in_fire = 1'b0;

    // Decoder state mirrored by the predictor.
    dec_phase_e    ph = P_LEAD;
    logic [SZ-1:0] size_acc = '0;
    logic          digit_seen = 1'b0;
    logic          lone_zero = 1'b0;
    logic [SZ-1:0] remaining = '0;

    chunked_transfer_decoder_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .start_body    (start_body),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .payload_valid (payload_valid),
        .chunk_last    (chunk_last),
        .body_done     (body_done),
        .format_error  (format_error)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit blank_char(input logic [7:0] c);
        case (c)
            cdec_pkg::CH_SPACE, cdec_pkg::CH_TAB, cdec_pkg::CH_CR, cdec_pkg::CH_VT,
            cdec_pkg::CH_FF: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Bit 4 marks a hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return {1'b1, 4'(c - 8'h30)};
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            return {1'b1, 4'(c - 8'h61 + 8'd10)};
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        return 5'd0;
    endfunction

    function automatic bit take_digit(input logic [3:0] v, input bit may_prefix);
        if (size_acc > (SIZE_LIMIT >> 4))
        begin
            return 1'b0;
        end
        size_acc = {size_acc[SZ-5:0], v};
        lone_zero = may_prefix && !digit_seen && (v == 4'd0);
        digit_seen = 1'b1;
        return 1'b1;
    endfunction

    function automatic void close_line();
        if (!digit_seen)
        begin
            ph = P_ERROR;
        end
        else
        begin
            if (size_acc == '0)
            begin
                ph = P_DONE;
            end
            else
            begin
                remaining = size_acc;
                ph = P_PAYLOAD;
            end
            size_acc = '0;
            digit_seen = 1'b0;
            lone_zero = 1'b0;
        end
    endfunction

    task automatic decode_byte(input logic [7:0] c, input logic st,
                               output cdec_pkg::result_t r);
        logic [4:0] hv;
        r = '0;
        if (st)
        begin
            ph = P_LEAD;
            size_acc = '0;
            digit_seen = 1'b0;
            lone_zero = 1'b0;
            remaining = '0;
        end
        hv = nibble_of(c);
        case (ph)
            P_LEAD, P_SIGN:
            begin
                if (c == cdec_pkg::CH_LF)
                    ph = P_ERROR;
                else if (ph == P_LEAD && blank_char(c))
                    ph = P_LEAD;
                else if (ph == P_LEAD && c == cdec_pkg::CH_PLUS)
                    ph = P_SIGN;
                else if (hv[4])
                    ph = take_digit(hv[3:0], 1'b1) ? P_DIGITS : P_ERROR;
                else
                    ph = P_ERROR;
            end
            P_DIGITS:
            begin
                if (c == cdec_pkg::CH_LF)
                    close_line();
                else if (hv[4])
                begin
                    if (!take_digit(hv[3:0], 1'b0))
                        ph = P_ERROR;
                end
                else if ((c == cdec_pkg::CH_LOW_X || c == cdec_pkg::CH_UP_X) && lone_zero)
                begin
                    // The prefix is taken, so the digits start over.
                    lone_zero = 1'b0;
                    digit_seen = 1'b0;
                    size_acc = '0;
                end
                else if (blank_char(c) && digit_seen)
                    ph = P_TRAIL;
                else
                    ph = P_ERROR;
            end
            P_TRAIL:
            begin
                if (c == cdec_pkg::CH_LF)
                    close_line();
                else if (!blank_char(c))
                    ph = P_ERROR;
            end
            P_PAYLOAD:
            begin
                r.out_byte = c;
                r.payload_valid = 1'b1;
                remaining = remaining - SZ'(1);
                if (remaining == '0)
                begin
                    r.chunk_last = 1'b1;
                    ph = P_SKIP;
                end
            end
            P_SKIP:
            begin
                if (c == cdec_pkg::CH_LF)
                    ph = P_LEAD;
            end
            default:
            begin
            end
        endcase
        r.body_done = (ph == P_DONE);
        r.format_error = (ph == P_ERROR);
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // Idling is suppressed over one window of cycles.
    function automatic bit idle_now();
        return (cyc < 300 || cyc >= 600) && ($urandom_range(0, 99) < 7);
    endfunction

    always @(negedge clk)
    begin : drive_requests
        req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (pending.size() != 0 && !idle_now())
            begin
                nxt = pending.pop_front();
                in_valid <= 1'b1;
                in_byte <= nxt.b;
                start_body <= nxt.st;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= rst_n && !idle_now();
    end

    always @(posedge clk)
    begin : watch_results
        cdec_pkg::result_t got;
        cdec_pkg::result_t want;
        cdec_pkg::result_t pred;
        cyc++;
        in_fire = rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.out_byte = out_byte;
                got.payload_valid = payload_valid;
                got.chunk_last = chunk_last;
                got.body_done = body_done;
                got.format_error = format_error;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with none expected, expected nothing actual %0h",
                             $time, got);
                    err_cnt++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("out_byte", want.out_byte, got.out_byte);
                    check_field("payload_valid", 8'(want.payload_valid),
                                8'(got.payload_valid));
                    check_field("chunk_last", 8'(want.chunk_last), 8'(got.chunk_last));
                    check_field("body_done", 8'(want.body_done), 8'(got.body_done));
                    check_field("format_error", 8'(want.format_error),
                                8'(got.format_error));
                end
            end
            if (in_fire)
            begin
                decode_byte(in_byte, start_body, pred);
                expected_results.push_back(pred);
            end
        end
    end

    task automatic put_byte(input logic [7:0] b, input logic st, input bit counted = 1'b1);
        req_t r;
        r.b = b;
        r.st = st;
        pending.push_back(r);
        if (counted)
            items_sent++;
    endtask

    task automatic push_text(input string s, input logic st);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i], st && (i == 0));
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0: return cdec_pkg::CH_SPACE;
            1: return cdec_pkg::CH_TAB;
            2: return cdec_pkg::CH_CR;
            3: return cdec_pkg::CH_VT;
            default: return cdec_pkg::CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit up);
        if (nib < 4'd10)
            return 8'(CH_ZERO + nib);
        return 8'((up ? CH_UP_A : CH_LOW_A) + nib - 8'd10);
    endfunction

    function automatic logic [7:0] any_but_lf();
        logic [7:0] b;
        b = 8'($urandom_range(0, 254));
        if (b >= cdec_pkg::CH_LF)
            b = b + 8'd1;
        return b;
    endfunction

    task automatic add_size_line(input logic [SZ-1:0] size);
        int nd;
        if ($urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 2)) body_q.push_back(pick_blank());
        if ($urandom_range(0, 99) < 20)
            body_q.push_back(cdec_pkg::CH_PLUS);
        if ($urandom_range(0, 99) < 25)
        begin
            body_q.push_back(CH_ZERO);
            body_q.push_back($urandom_range(0, 1) ? cdec_pkg::CH_LOW_X : cdec_pkg::CH_UP_X);
        end
        if ($urandom_range(0, 99) < 15)
            body_q.push_back(CH_ZERO);
        nd = 1;
        while (nd < 8 && (size >> (4 * nd)) != 0)
            nd++;
        for (int i = nd - 1; i >= 0; i--)
            body_q.push_back(hex_char(4'(size >> (4 * i)), $urandom_range(0, 1) != 0));
        if ($urandom_range(0, 99) < 20)
            repeat ($urandom_range(1, 2)) body_q.push_back(pick_blank());
        body_q.push_back(cdec_pkg::CH_LF);
    endtask

    task automatic add_chunk(input int unsigned size);
        add_size_line(SZ'(size));
        repeat (size) body_q.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3)) body_q.push_back(any_but_lf());
        body_q.push_back(cdec_pkg::CH_LF);
    endtask

    // Mode 0 sends a clean body, 1 cuts it short, 2 corrupts one byte.
    task automatic send_body(input int mode);
        int cut;
        int pos;
        body_q.delete();
        repeat ($urandom_range(1, 3))
            add_chunk(($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                   : $urandom_range(1, 6));
        add_size_line('0);
        cut = body_q.size();
        if (mode == 1)
            cut = $urandom_range(1, body_q.size() - 1);
        if (mode == 2)
        begin
            pos = $urandom_range(0, body_q.size() - 1);
            body_q[pos] = 8'($urandom_range(0, 255));
        end
        for (int i = 0; i < cut; i++)
            put_byte(body_q[i], i == 0);
        // Bytes after the terminating chunk are ignored by the decoder.
        if (mode == 0 && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    endtask

    // Size lines at and just past the widest value.
    task automatic send_wide();
        case ($urandom_range(0, 3))
            0: push_text("80000000", 1'b1);
            1: push_text("0x7fffffff0", 1'b1);
            2: push_text("7FFFFFFF\n", 1'b1);
            default: push_text("+0X00000007FFFFFFFF\n", 1'b1);
        endcase
        repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : run_stimulus
        int k;
        // Prefix, plus sign, payload extremes and a CR before the LF.
        push_text("+0x2\n", 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        push_text("\r\n", 1'b0);
        // Terminating chunk, then a byte that must be ignored.
        push_text("0\n", 1'b0);
        put_byte(8'h41, 1'b0);
        push_text("\n", 1'b1);
        push_text("1 2", 1'b1);
        push_text("-", 1'b1);
        push_text("++", 1'b1);
        push_text("1;", 1'b1);
        push_text("0x\n", 1'b1);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The sender holds off here until the decoder has caught up.
        wait_drained();
        repeat (4) @(posedge clk);

        items_sent = 0;
        while (items_sent < 700)
        begin
            k = $urandom_range(0, 99);
            if (k < 65)
                send_body(0);
            else if (k < 75)
                send_body(1);
            else if (k < 83)
                send_body(2);
            else if (k < 90)
                send_wide();
            else
                repeat ($urandom_range(1, 12))
                    put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end

        wait_drained();
        repeat (5) @(posedge clk);
        if (err_cnt == 0)
            $display("chunked_transfer_decoder_top regression: pass");
        else
            $display("chunked_transfer_decoder_top regression: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("chunked_transfer_decoder_top regression: fail");
        $finish;
    end

endmodule
